@@ rtl/hsps_pkg.sv @@
// Package of shared types, codes and reset values for the SPS size extractor.
package hsps_pkg;

    localparam logic [15:0] LIMIT_RESET   = 16'd1500;
    localparam logic [4:0]  NAL_SPS       = 5'd7;
    localparam logic [4:0]  NAL_STAP_A    = 5'd24;
    localparam logic [5:0]  SPS_ID_NONE   = 6'd32;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_NO_SPS      = 3'd1,
        ST_BAD_LEN     = 3'd2,
        ST_BAD_PROFILE = 3'd3,
        ST_SCALING     = 3'd4,
        ST_MALFORMED   = 3'd5
    } status_t;

    typedef enum logic [5:0] {
        E_IDLE, E_HEADER, E_PROFILE, E_SKIP1, E_SKIP2,
        S_SPS_ID, S_CHROMA, S_SEP, S_DEPTH_L, S_DEPTH_C, S_BYPASS,
        S_SCALE_PRESENT, S_SCALE_FLAGS, S_LOG2_FN, S_POC_TYPE, S_POC_LSB,
        S_DELTA_ZERO, S_OFF_NONREF, S_OFF_TB, S_NUM_CYCLE, S_CYCLE,
        S_MAX_REF, S_GAPS, S_WIDTH, S_HEIGHT, S_FMO, S_MBAFF, S_D8X8,
        S_CROP_FLAG, S_CROP_L, S_CROP_R, S_CROP_T, S_CROP_B, S_VUI
    } elem_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_beat_t;

    typedef struct packed {
        logic [4:0]         header_type;
        logic [2:0]         status;
        logic [5:0]         sps_id;
        logic signed [31:0] frame_width;
        logic signed [31:0] frame_height;
    } out_beat_t;

    // Fields order: width_m1, height_m1, left, right, top, bottom.
    typedef struct packed {
        elem_t            elem;
        logic             pending;
        logic             suffix;
        logic [5:0]       lz;
        logic [31:0]      acc;
        logic [7:0]       profile;
        logic [31:0]      chroma;
        logic [1:0]       mode;
        logic [31:0]      loopc;
        logic [5:0][31:0] fields;
        logic [5:0]       id;
        status_t          held_status;
        logic [5:0]       held_id;
    } sps_state_t;

    typedef struct packed {
        logic [4:0]       header_type;
        status_t          status;
        logic [5:0]       sps_id;
        logic [5:0][31:0] fields;
        logic [31:0]      chroma;
        logic [1:0]       mode;
    } result_t;

    function automatic sps_state_t sps_reset_state();
        sps_state_t s;
        s.elem        = E_IDLE;
        s.pending     = 1'b0;
        s.suffix      = 1'b0;
        s.lz          = '0;
        s.acc         = '0;
        s.profile     = '0;
        s.chroma      = 32'd1;
        s.mode        = '0;
        s.loopc       = '0;
        s.fields      = '0;
        s.id          = '0;
        s.held_status = ST_NO_SPS;
        s.held_id     = SPS_ID_NONE;
        return s;
    endfunction

endpackage

@@ rtl/hsps_sps_walker.sv @@
// Combinational walk of one byte through the SPS syntax, bit by bit.
module hsps_sps_walker (
    input  hsps_pkg::sps_state_t st_in,
    input  logic [7:0]           data_byte,
    input  logic                 feed_en,
    input  logic                 end_en,
    output hsps_pkg::sps_state_t st_out
);
    import hsps_pkg::*;

    localparam logic [7:0] PROFILE_BASELINE = 8'd66;

    function automatic logic high_profile(logic [7:0] p);
        return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
               p == 8'd44  || p == 8'd83  || p == 8'd86  || p == 8'd118 ||
               p == 8'd128 || p == 8'd138 || p == 8'd139 || p == 8'd134;
    endfunction

    function automatic logic is_ue(elem_t e);
        case (e) inside
            S_SPS_ID, S_CHROMA, S_DEPTH_L, S_DEPTH_C, S_LOG2_FN, S_POC_TYPE,
            S_POC_LSB, S_OFF_NONREF, S_OFF_TB, S_NUM_CYCLE, S_CYCLE, S_MAX_REF,
            S_WIDTH, S_HEIGHT, S_CROP_L, S_CROP_R, S_CROP_T, S_CROP_B: return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic sps_state_t conclude(sps_state_t s, status_t code);
        sps_state_t r;
        r = s;
        r.held_status = code;
        r.held_id     = (code == ST_OK) ? s.id : SPS_ID_NONE;
        r.pending     = 1'b0;
        r.elem        = E_IDLE;
        return r;
    endfunction

    function automatic sps_state_t sps_bit(sps_state_t s, logic b);
        sps_state_t r;
        logic [31:0] v;
        logic        done;
        r    = s;
        v    = {31'd0, b};
        done = 1'b1;
        if (is_ue(s.elem)) begin
            if (!s.suffix) begin
                if (!b) begin
                    r.lz = s.lz + 6'd1;
                    if (r.lz > 6'd31) begin
                        r.lz = '0;
                        return conclude(r, ST_MALFORMED);
                    end
                    done = 1'b0;
                end else begin
                    r.acc = 32'd1;
                    if (s.lz == '0) begin
                        v = '0;
                    end else begin
                        r.suffix = 1'b1;
                        done = 1'b0;
                    end
                end
            end else begin
                r.acc = {s.acc[30:0], b};
                r.lz  = s.lz - 6'd1;
                if (r.lz == '0) begin
                    r.suffix = 1'b0;
                    v = r.acc - 32'd1;
                end else begin
                    done = 1'b0;
                end
            end
        end
        if (!done) return r;
        unique case (s.elem)
            S_SPS_ID: begin
                r.id   = v[5:0];
                r.elem = (s.profile == PROFILE_BASELINE) ? S_LOG2_FN : S_CHROMA;
            end
            S_CHROMA: begin
                r.chroma = v;
                r.elem   = (v == 32'd3) ? S_SEP : S_DEPTH_L;
            end
            S_SEP: begin
                if (v[0]) r.mode[0] = 1'b1;
                r.elem = S_DEPTH_L;
            end
            S_DEPTH_L:  r.elem = S_DEPTH_C;
            S_DEPTH_C:  r.elem = S_BYPASS;
            S_BYPASS:   r.elem = S_SCALE_PRESENT;
            S_SCALE_PRESENT: begin
                if (v[0]) begin
                    r.loopc = (s.chroma != 32'd3) ? 32'd8 : 32'd12;
                    r.acc   = '0;
                    r.elem  = S_SCALE_FLAGS;
                end else begin
                    r.elem = S_LOG2_FN;
                end
            end
            S_SCALE_FLAGS: begin
                r.acc   = {s.acc[30:0], v[0]};
                r.loopc = s.loopc - 32'd1;
                if (r.loopc == '0) begin
                    if (r.acc != '0) return conclude(r, ST_SCALING);
                    r.elem = S_LOG2_FN;
                end
            end
            S_LOG2_FN:  r.elem = S_POC_TYPE;
            S_POC_TYPE: r.elem = (v == 32'd0) ? S_POC_LSB :
                                 (v == 32'd1) ? S_DELTA_ZERO : S_MAX_REF;
            S_POC_LSB:    r.elem = S_MAX_REF;
            S_DELTA_ZERO: r.elem = S_OFF_NONREF;
            S_OFF_NONREF: r.elem = S_OFF_TB;
            S_OFF_TB:     r.elem = S_NUM_CYCLE;
            S_NUM_CYCLE: begin
                r.loopc = v[31] ? 32'd0 : v;
                r.elem  = (r.loopc != '0) ? S_CYCLE : S_MAX_REF;
            end
            S_CYCLE: begin
                r.loopc = s.loopc - 32'd1;
                if (r.loopc == '0) r.elem = S_MAX_REF;
            end
            S_MAX_REF: r.elem = S_GAPS;
            S_GAPS:    r.elem = S_WIDTH;
            S_WIDTH: begin
                r.fields[0] = v;
                r.elem      = S_HEIGHT;
            end
            S_HEIGHT: begin
                r.fields[1] = v;
                r.elem      = S_FMO;
            end
            S_FMO: begin
                if (v[0]) begin
                    r.mode[1] = 1'b1;
                    r.elem    = S_D8X8;
                end else begin
                    r.elem = S_MBAFF;
                end
            end
            S_MBAFF:     r.elem = S_D8X8;
            S_D8X8:      r.elem = S_CROP_FLAG;
            S_CROP_FLAG: r.elem = v[0] ? S_CROP_L : S_VUI;
            S_CROP_L: begin
                r.fields[2] = v;
                r.elem      = S_CROP_R;
            end
            S_CROP_R: begin
                r.fields[3] = v;
                r.elem      = S_CROP_T;
            end
            S_CROP_T: begin
                r.fields[4] = v;
                r.elem      = S_CROP_B;
            end
            S_CROP_B: begin
                r.fields[5] = v;
                r.elem      = S_VUI;
            end
            S_VUI:   return conclude(r, ST_OK);
            default: return conclude(r, ST_MALFORMED);
        endcase
        return r;
    endfunction

    always_comb begin
        sps_state_t s;
        s = st_in;
        if (feed_en) begin
            if (s.elem == E_HEADER) begin
                if (data_byte[4:0] == NAL_SPS) begin
                    s.pending = 1'b1;
                    s.suffix  = 1'b0;
                    s.lz      = '0;
                    s.acc     = '0;
                    s.profile = '0;
                    s.chroma  = 32'd1;
                    s.mode    = '0;
                    s.loopc   = '0;
                    s.id      = '0;
                    s.fields  = '0;
                    s.elem    = E_PROFILE;
                end else begin
                    s.elem = E_IDLE;
                end
            end else if (s.pending) begin
                case (s.elem)
                    E_PROFILE: begin
                        s.profile = data_byte;
                        if (data_byte != PROFILE_BASELINE && !high_profile(data_byte)) begin
                            s = conclude(s, ST_BAD_PROFILE);
                        end else begin
                            s.elem = E_SKIP1;
                        end
                    end
                    E_SKIP1: s.elem = E_SKIP2;
                    E_SKIP2: s.elem = S_SPS_ID;
                    default: begin
                        for (int i = 7; i >= 0; i--) begin
                            if (s.pending) s = sps_bit(s, data_byte[i]);
                        end
                    end
                endcase
            end
        end
        if (end_en) begin
            if (s.pending) s = conclude(s, ST_MALFORMED);
            s.elem = E_IDLE;
        end
        st_out = s;
    end

endmodule

@@ rtl/hsps_size_calc.sv @@
// Cropped luma size and result beat formed from the registered parse result.
module hsps_size_calc (
    input  hsps_pkg::result_t   res,
    output hsps_pkg::out_beat_t beat
);
    import hsps_pkg::*;

    logic [31:0] cat;
    logic        sx;
    logic        field_sh;
    logic [1:0]  sy;
    logic [31:0] w_full;
    logic [31:0] h_full;
    logic [31:0] crop_x;
    logic [31:0] crop_y;

    always_comb begin
        cat      = res.mode[0] ? 32'd0 : res.chroma;
        sx       = (cat == 32'd1) || (cat == 32'd2);
        field_sh = !res.mode[1];
        sy       = {1'b0, cat == 32'd1} + {1'b0, field_sh};
        w_full   = (res.fields[0] + 32'd1) << 4;
        h_full   = (res.fields[1] + 32'd1) << (3'd4 + {2'b00, field_sh});
        crop_x   = (res.fields[2] + res.fields[3]) << sx;
        crop_y   = (res.fields[4] + res.fields[5]) << sy;

        beat.header_type = res.header_type;
        beat.status      = res.status;
        beat.sps_id      = res.sps_id;
        if (res.status == ST_OK) begin
            beat.frame_width  = w_full - crop_x;
            beat.frame_height = h_full - crop_y;
        end else begin
            beat.frame_width  = '0;
            beat.frame_height = '0;
        end
    end

endmodule

@@ rtl/h264_sps_size_extractor_unit.sv @@
// Top level of the SPS size extractor: beat registers, packet framing, result register.
// A result beat is captured in the result register when the last byte's beat leaves the input register.
// Throughput: one byte beat per cycle while no result stalls, set by the combinational syntax walk of a byte.
// A result beat waiting on m_ready stalls only a following last-byte beat.
// Reset (aresetn low, synchronous) empties both registers, awaits a first byte
// and restores the length limit (limit_reg) to 1500.
module h264_sps_size_extractor_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hsps_pkg::in_beat_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hsps_pkg::out_beat_t m_data,
    input  logic                cfg_wr_en,
    input  logic [15:0]         cfg_wr_data
);
    import hsps_pkg::*;

    // Framing phases of the payload: first byte, single unit, aggregate size bytes, unit body, drop.
    typedef enum logic [2:0] {
        PH_FIRST, PH_SINGLE, PH_LEN_HI, PH_LEN_LO, PH_UNIT, PH_DROP
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [15:0] bc_reg, bc_next;
    logic [15:0] rem_reg, rem_next;
    logic [4:0]  type_reg, type_next;
    sps_state_t  st_reg, st_next;
    logic [15:0] limit_reg;

    in_beat_t   in_reg;
    logic       in_valid_reg;
    result_t    res_reg, res_next;
    logic       m_valid_reg;

    sps_state_t walk_in;
    logic       feed_en;
    logic       unit_end;
    logic       end_en;
    logic       advance;
    status_t    status;

    // The input register moves on unless it holds a last byte whose result
    // has nowhere to go because the previous result is still waiting.
    assign advance = in_valid_reg &&
                     (!in_reg.last_byte || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = m_valid_reg;

    // Packet framing ahead of the syntax walk.
    always_comb begin
        phase_next = phase_reg;
        rem_next   = rem_reg;
        type_next  = type_reg;
        bc_next    = (bc_reg != 16'hffff) ? bc_reg + 16'd1 : bc_reg;
        walk_in    = st_reg;
        feed_en    = 1'b0;
        unit_end   = 1'b0;
        unique case (phase_reg)
            PH_FIRST: begin
                walk_in   = sps_reset_state();
                bc_next   = 16'd1;
                rem_next  = '0;
                type_next = in_reg.data_byte[4:0];
                if (in_reg.data_byte[4:0] == NAL_SPS) begin
                    phase_next   = PH_SINGLE;
                    walk_in.elem = E_HEADER;
                    feed_en      = 1'b1;
                end else if (in_reg.data_byte[4:0] == NAL_STAP_A) begin
                    phase_next = PH_LEN_HI;
                end else begin
                    phase_next = PH_DROP;
                end
            end
            PH_SINGLE: feed_en = 1'b1;
            PH_LEN_HI: begin
                rem_next   = {in_reg.data_byte, 8'h00};
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                rem_next = {rem_reg[15:8], in_reg.data_byte};
                if (rem_next != '0) begin
                    phase_next   = PH_UNIT;
                    walk_in.elem = E_HEADER;
                end else begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_UNIT: begin
                feed_en  = 1'b1;
                rem_next = rem_reg - 16'd1;
                if (rem_next == '0) begin
                    unit_end   = 1'b1;
                    phase_next = PH_LEN_HI;
                end
            end
            PH_DROP: ;
            default: phase_next = PH_FIRST;
        endcase
        // A unit still open when the packet ends is closed here as well.
        end_en = unit_end || (in_reg.last_byte &&
                 (phase_next == PH_SINGLE || phase_next == PH_UNIT));
    end

    hsps_sps_walker u_walker (
        .st_in     (walk_in),
        .data_byte (in_reg.data_byte),
        .feed_en   (feed_en),
        .end_en    (end_en),
        .st_out    (st_next)
    );

    // The length check takes priority over anything the walk has found.
    always_comb begin
        if (bc_next < 16'd4 || bc_next >= limit_reg) begin
            status = ST_BAD_LEN;
        end else if (type_next == NAL_SPS || type_next == NAL_STAP_A) begin
            status = st_next.held_status;
        end else begin
            status = ST_NO_SPS;
        end
        res_next.header_type = type_next;
        res_next.status      = status;
        res_next.sps_id      = (status == ST_OK) ? st_next.held_id : SPS_ID_NONE;
        res_next.fields      = st_next.fields;
        res_next.chroma      = st_next.chroma;
        res_next.mode        = st_next.mode;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
            phase_reg    <= PH_FIRST;
            bc_reg       <= '0;
            rem_reg      <= '0;
            type_reg     <= '0;
            st_reg       <= sps_reset_state();
            limit_reg    <= LIMIT_RESET;
        end else begin
            if (cfg_wr_en) limit_reg <= cfg_wr_data;
            if (s_valid && s_ready) begin
                in_reg <= s_data;
            end
            if (s_ready) in_valid_reg <= s_valid;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (advance) begin
                type_reg <= type_next;
                if (in_reg.last_byte) begin
                    // Packet complete: capture the result and start afresh.
                    res_reg     <= res_next;
                    m_valid_reg <= 1'b1;
                    phase_reg   <= PH_FIRST;
                    bc_reg      <= '0;
                    rem_reg     <= '0;
                    st_reg      <= sps_reset_state();
                end else begin
                    phase_reg <= phase_next;
                    bc_reg    <= bc_next;
                    rem_reg   <= rem_next;
                    st_reg    <= st_next;
                end
            end
        end
    end

    hsps_size_calc u_size (
        .res  (res_reg),
        .beat (m_data)
    );

`ifndef ASSERT_OFF
    a_id_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.sps_id == SPS_ID_NONE)
        else $error("sps_id not 32 on an error result");
    a_size_on_error: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.status != ST_OK |-> m_data.frame_width == 0 &&
        m_data.frame_height == 0)
        else $error("nonzero size on an error result");
    a_held_stays: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |=> in_valid_reg && $stable(in_reg))
        else $error("stalled input beat lost");
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !advance |-> m_valid && !m_ready && in_reg.last_byte)
        else $error("input stalled without a waiting result");
`endif

endmodule

@@ bench/h264_sps_size_extractor_unit_tb.sv @@
// Self-checking testbench for the H.264 SPS frame size extractor.
`timescale 1ns / 1ps

module h264_sps_size_extractor_unit_tb;
    import hsps_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 16;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_valid = 1'b0;
    logic            s_ready;
    in_beat_t        s_data = '0;
    logic            m_valid;
    logic            m_ready = 1'b0;
    out_beat_t       m_data;
    logic            cfg_wr_en = 1'b0;
    logic [15:0]     cfg_wr_data = '0;

    h264_sps_size_extractor_unit i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    // Byte beats still to be driven, and size results still to be received.
    in_beat_t  byte_queue[$];
    out_beat_t size_queue[$];
    int        error_count = 0;
    int        cycle_count = 0;
    bit        idle_enable = 1'b0;
    bit        drive_enable = 1'b0;

    // Mirror of the parser state.
    localparam int PH_FIRST = 0, PH_SINGLE = 1, PH_LEN_HI = 2, PH_LEN_LO = 3,
                   PH_UNIT = 4, PH_DROP = 5;
    logic [15:0] len_limit;
    int          phase;
    logic [15:0] bytes_seen;
    logic [15:0] unit_left;
    elem_t       elem;
    logic [5:0]  zeros;
    logic [31:0] acc;
    logic [7:0]  profile;
    logic [31:0] chroma_idc;
    logic [1:0]  mode;
    logic [31:0] loopc;
    logic [31:0] dims[6];
    logic [2:0]  held_status;
    logic [5:0]  held_id;
    logic [31:0] held_w, held_h;
    bit          pending, in_suffix;
    logic [31:0] cur_id;
    logic [4:0]  pkt_type;

    function automatic bit is_high_profile(logic [7:0] p);
        return p inside {8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83, 8'd86,
                         8'd118, 8'd128, 8'd138, 8'd139, 8'd134};
    endfunction

    function automatic bit elem_is_golomb(elem_t e);
        return e inside {S_SPS_ID, S_CHROMA, S_DEPTH_L, S_DEPTH_C, S_LOG2_FN,
                         S_POC_TYPE, S_POC_LSB, S_OFF_NONREF, S_OFF_TB,
                         S_NUM_CYCLE, S_CYCLE, S_MAX_REF, S_WIDTH, S_HEIGHT,
                         S_CROP_L, S_CROP_R, S_CROP_T, S_CROP_B};
    endfunction

    task automatic settle_sps(logic [2:0] st, logic [31:0] w, logic [31:0] h);
        held_status = st;
        if (st != ST_OK) begin
            held_id = SPS_ID_NONE;
            held_w = '0;
            held_h = '0;
        end else begin
            held_id = cur_id[5:0];
            held_w = w;
            held_h = h;
        end
        pending = 1'b0;
        elem = E_IDLE;
    endtask

    task automatic clear_packet();
        phase = PH_FIRST;
        bytes_seen = '0;
        unit_left = '0;
        elem = E_IDLE;
        zeros = '0;
        acc = '0;
        profile = '0;
        chroma_idc = 32'd1;
        mode = '0;
        loopc = '0;
        foreach (dims[i]) dims[i] = '0;
        pending = 1'b0;
        in_suffix = 1'b0;
        cur_id = '0;
        held_status = ST_NO_SPS;
        held_id = SPS_ID_NONE;
        held_w = '0;
        held_h = '0;
    endtask

    task automatic open_sps();
        pending = 1'b1;
        in_suffix = 1'b0;
        zeros = '0;
        acc = '0;
        profile = '0;
        chroma_idc = 32'd1;
        mode = '0;
        loopc = '0;
        cur_id = '0;
        foreach (dims[i]) dims[i] = '0;
        elem = E_PROFILE;
    endtask

    task automatic close_sps_ok();
        logic [31:0] fmul, cat, ux, uy, w, h;
        fmul = 32'd2 - mode[1];
        cat = mode[0] ? 32'd0 : chroma_idc;
        ux = (cat == 1 || cat == 2) ? 32'd2 : 32'd1;
        uy = ((cat == 1) ? 32'd2 : 32'd1) * fmul;
        w = (dims[0] + 1) * 16 - (dims[2] + dims[3]) * ux;
        h = fmul * (dims[1] + 1) * 16 - (dims[4] + dims[5]) * uy;
        settle_sps(ST_OK, w, h);
    endtask

    // One bit of the SPS syntax walk.
    task automatic walk_bit(logic b);
        elem_t       e;
        logic [31:0] v;
        bit          got;
        e = elem;
        v = {31'd0, b};
        if (elem_is_golomb(e)) begin
            got = 1'b0;
            if (!in_suffix) begin
                if (!b) begin
                    zeros++;
                    if (zeros > 31) begin
                        zeros = '0;
                        settle_sps(ST_MALFORMED, 0, 0);
                        return;
                    end
                end else begin
                    acc = 32'd1;
                    if (zeros == 0) begin
                        v = 0;
                        got = 1'b1;
                    end else begin
                        in_suffix = 1'b1;
                    end
                end
            end else begin
                acc = {acc[30:0], b};
                zeros--;
                if (zeros == 0) begin
                    in_suffix = 1'b0;
                    v = acc - 1;
                    got = 1'b1;
                end
            end
            if (!got) return;
        end
        case (e)
            S_SPS_ID: begin
                cur_id = v;
                e = (profile == 8'd66) ? S_LOG2_FN : S_CHROMA;
            end
            S_CHROMA: begin
                chroma_idc = v;
                e = (v == 3) ? S_SEP : S_DEPTH_L;
            end
            S_SEP: begin
                if (v != 0) mode[0] = 1'b1;
                e = S_DEPTH_L;
            end
            S_DEPTH_L: e = S_DEPTH_C;
            S_DEPTH_C: e = S_BYPASS;
            S_BYPASS: e = S_SCALE_PRESENT;
            S_SCALE_PRESENT: begin
                if (v != 0) begin
                    loopc = (chroma_idc != 3) ? 32'd8 : 32'd12;
                    acc = '0;
                    e = S_SCALE_FLAGS;
                end else begin
                    e = S_LOG2_FN;
                end
            end
            S_SCALE_FLAGS: begin
                acc = {acc[30:0], v[0]};
                loopc--;
                if (loopc == 0) begin
                    if (acc != 0) begin
                        settle_sps(ST_SCALING, 0, 0);
                        return;
                    end
                    e = S_LOG2_FN;
                end
            end
            S_LOG2_FN: e = S_POC_TYPE;
            S_POC_TYPE: e = (v == 0) ? S_POC_LSB : (v == 1) ? S_DELTA_ZERO : S_MAX_REF;
            S_POC_LSB: e = S_MAX_REF;
            S_DELTA_ZERO: e = S_OFF_NONREF;
            S_OFF_NONREF: e = S_OFF_TB;
            S_OFF_TB: e = S_NUM_CYCLE;
            S_NUM_CYCLE: begin
                loopc = v[31] ? 32'd0 : v;
                e = (loopc != 0) ? S_CYCLE : S_MAX_REF;
            end
            S_CYCLE: begin
                loopc--;
                if (loopc == 0) e = S_MAX_REF;
            end
            S_MAX_REF: e = S_GAPS;
            S_GAPS: e = S_WIDTH;
            S_WIDTH: begin
                dims[0] = v;
                e = S_HEIGHT;
            end
            S_HEIGHT: begin
                dims[1] = v;
                e = S_FMO;
            end
            S_FMO: begin
                if (v != 0) begin
                    mode[1] = 1'b1;
                    e = S_D8X8;
                end else begin
                    e = S_MBAFF;
                end
            end
            S_MBAFF: e = S_D8X8;
            S_D8X8: e = S_CROP_FLAG;
            S_CROP_FLAG: e = (v != 0) ? S_CROP_L : S_VUI;
            S_CROP_L: begin dims[2] = v; e = S_CROP_R; end
            S_CROP_R: begin dims[3] = v; e = S_CROP_T; end
            S_CROP_T: begin dims[4] = v; e = S_CROP_B; end
            S_CROP_B: begin dims[5] = v; e = S_VUI; end
            S_VUI: begin
                close_sps_ok();
                return;
            end
            default: begin
                settle_sps(ST_MALFORMED, 0, 0);
                return;
            end
        endcase
        elem = e;
    endtask

    task automatic unit_byte(logic [7:0] b);
        if (elem == E_HEADER) begin
            if (b[4:0] == NAL_SPS) open_sps();
            else elem = E_IDLE;
            return;
        end
        if (!pending) return;
        case (elem)
            E_PROFILE: begin
                profile = b;
                if (b != 8'd66 && !is_high_profile(b)) settle_sps(ST_BAD_PROFILE, 0, 0);
                else elem = E_SKIP1;
            end
            E_SKIP1: elem = E_SKIP2;
            E_SKIP2: elem = S_SPS_ID;
            default: begin
                for (int i = 7; i >= 0; i--) begin
                    if (pending) walk_bit(b[i]);
                end
            end
        endcase
    endtask

    task automatic close_unit();
        if (pending) settle_sps(ST_MALFORMED, 0, 0);
        elem = E_IDLE;
    endtask

    // Advances the predicted parser by one accepted byte beat and queues
    // the size result that a last byte produces.
    task automatic predict_byte(in_beat_t beat);
        logic [7:0] b;
        logic [2:0] st;
        out_beat_t  r;
        b = beat.data_byte;
        if (bytes_seen != 16'hffff) bytes_seen++;
        case (phase)
            PH_FIRST: begin
                clear_packet();
                bytes_seen = 16'd1;
                pkt_type = b[4:0];
                if (pkt_type == NAL_SPS) begin
                    phase = PH_SINGLE;
                    elem = E_HEADER;
                    unit_byte(b);
                end else if (pkt_type == NAL_STAP_A) begin
                    phase = PH_LEN_HI;
                end else begin
                    phase = PH_DROP;
                end
            end
            PH_SINGLE: unit_byte(b);
            PH_LEN_HI: begin
                unit_left = {b, 8'd0};
                phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                unit_left[7:0] = b;
                if (unit_left != 0) begin
                    phase = PH_UNIT;
                    elem = E_HEADER;
                end else begin
                    phase = PH_LEN_HI;
                end
            end
            PH_UNIT: begin
                unit_byte(b);
                unit_left--;
                if (unit_left == 0) begin
                    close_unit();
                    phase = PH_LEN_HI;
                end
            end
            default: ;
        endcase
        if (!beat.last_byte) return;
        if (phase == PH_SINGLE || phase == PH_UNIT) close_unit();
        if (bytes_seen < 4 || bytes_seen >= len_limit) st = ST_BAD_LEN;
        else if (pkt_type == NAL_SPS || pkt_type == NAL_STAP_A) st = held_status;
        else st = ST_NO_SPS;
        r.header_type = pkt_type;
        r.status = st;
        r.sps_id = (st == ST_OK) ? held_id : SPS_ID_NONE;
        r.frame_width = (st == ST_OK) ? held_w : 32'd0;
        r.frame_height = (st == ST_OK) ? held_h : 32'd0;
        size_queue.push_back(r);
        clear_packet();
    endtask

    // Stimulus helpers: an SPS is assembled as a bit string, most significant first.
    bit bitstr[$];

    function automatic void put_bits(logic [31:0] v, int n);
        for (int i = n - 1; i >= 0; i--) bitstr.push_back(v[i]);
    endfunction

    function automatic void put_ue(logic [31:0] v);
        logic [32:0] c;
        int          n;
        c = {1'b0, v} + 33'd1;
        n = 0;
        for (int i = 32; i >= 0; i--) begin
            if (c[i] && n == 0) n = i;
        end
        for (int i = 0; i < n; i++) bitstr.push_back(1'b0);
        for (int i = n; i >= 0; i--) bitstr.push_back(c[i]);
    endfunction

    function automatic logic [31:0] rnd_small();
        case ($urandom_range(0, 9))
            0: return $urandom;
            1: return $urandom_range(0, 4095);
            default: return $urandom_range(0, 8);
        endcase
    endfunction

    // Builds an SPS unit (header, profile, two bytes, walked syntax).
    // fault: 0 none, 1 truncated, 2 scaling flag set, 3 too many zeros.
    function automatic void build_sps(ref logic [7:0] u[$], input logic [7:0] prof,
                                      input int fault);
        logic [31:0] cfi, poc, ncyc;
        int          nflags;
        bitstr.delete();
        u.delete();
        u.push_back({3'($urandom_range(0, 7)), NAL_SPS});
        u.push_back(prof);
        u.push_back(8'($urandom));
        u.push_back(8'($urandom));
        if (fault == 3) begin
            put_bits(0, 32);
            put_bits(1, 1);
        end
        put_ue($urandom_range(0, 3) == 0 ? $urandom_range(0, 63) : $urandom_range(0, 31));
        if (prof != 8'd66) begin
            cfi = $urandom_range(0, 4);
            put_ue(cfi);
            if (cfi == 3) put_bits($urandom_range(0, 1), 1);
            put_ue($urandom_range(0, 6));
            put_ue($urandom_range(0, 6));
            put_bits($urandom_range(0, 1), 1);
            if ($urandom_range(0, 2) == 0 || fault == 2) begin
                put_bits(1, 1);
                nflags = (cfi == 3) ? 12 : 8;
                put_bits(fault == 2 ? (32'd1 << $urandom_range(0, nflags - 1)) : 0, nflags);
            end else begin
                put_bits(0, 1);
            end
        end
        put_ue($urandom_range(0, 12));
        poc = $urandom_range(0, 3);
        put_ue(poc);
        if (poc == 0) put_ue($urandom_range(0, 12));
        else if (poc == 1) begin
            put_bits($urandom_range(0, 1), 1);
            put_ue(rnd_small());
            put_ue(rnd_small());
            ncyc = ($urandom_range(0, 9) == 0) ? 32'h8000_0000 | $urandom : $urandom_range(0, 4);
            put_ue(ncyc);
            if (!ncyc[31]) begin
                for (int i = 0; i < ncyc; i++) put_ue(rnd_small());
            end
        end
        put_ue($urandom_range(0, 16));
        put_bits($urandom_range(0, 1), 1);
        put_ue(rnd_small());
        put_ue(rnd_small());
        put_bits($urandom_range(0, 1), 1);
        if (bitstr[$]) put_bits(0, 0);
        else put_bits($urandom_range(0, 1), 1);
        put_bits($urandom_range(0, 1), 1);
        if ($urandom_range(0, 1)) begin
            put_bits(1, 1);
            repeat (4) put_ue(rnd_small());
        end else begin
            put_bits(0, 1);
        end
        put_bits($urandom_range(0, 1), 1);
        if (fault == 1) begin
            repeat ($urandom_range(1, 8)) void'(bitstr.pop_back());
        end
        while (bitstr.size() % 8 != 0) bitstr.push_back(1'($urandom_range(0, 1)));
        for (int i = 0; i < bitstr.size(); i += 8) begin
            u.push_back({bitstr[i], bitstr[i+1], bitstr[i+2], bitstr[i+3],
                         bitstr[i+4], bitstr[i+5], bitstr[i+6], bitstr[i+7]});
        end
        if (fault == 1 && u.size() > 5 && $urandom_range(0, 1)) begin
            repeat ($urandom_range(1, u.size() - 5)) void'(u.pop_back());
        end
    endfunction

    function automatic logic [7:0] pick_profile();
        logic [7:0] profs[13] = '{8'd66, 8'd100, 8'd110, 8'd122, 8'd244, 8'd44, 8'd83,
                                  8'd86, 8'd118, 8'd128, 8'd138, 8'd139, 8'd134};
        if ($urandom_range(0, 15) == 0) return 8'($urandom);
        return profs[$urandom_range(0, 12)];
    endfunction

    function automatic int pick_fault();
        case ($urandom_range(0, 11))
            0: return 1;
            1: return 2;
            2: return 3;
            default: return 0;
        endcase
    endfunction

    function automatic void send_packet(logic [7:0] pkt[$]);
        in_beat_t beat;
        foreach (pkt[i]) begin
            beat.data_byte = pkt[i];
            beat.last_byte = (i == pkt.size() - 1);
            byte_queue.push_back(beat);
        end
    endfunction

    // Random packet: mostly single SPS units and aggregates, some noise.
    function automatic void random_packet();
        logic [7:0] pkt[$];
        logic [7:0] u[$];
        int         kind;
        kind = $urandom_range(0, 9);
        pkt.delete();
        if (kind < 5) begin
            build_sps(pkt, pick_profile(), pick_fault());
        end else if (kind < 8) begin
            pkt.push_back({3'($urandom_range(0, 7)), NAL_STAP_A});
            repeat ($urandom_range(1, 3)) begin
                case ($urandom_range(0, 5))
                    0: begin
                        pkt.push_back(8'd0);
                        pkt.push_back(8'd0);
                    end
                    1: begin
                        u.delete();
                        repeat ($urandom_range(1, 6)) u.push_back(8'($urandom));
                        pkt.push_back(8'd0);
                        pkt.push_back(8'(u.size()));
                        foreach (u[i]) pkt.push_back(u[i]);
                    end
                    default: begin
                        build_sps(u, pick_profile(), pick_fault());
                        pkt.push_back(8'd0);
                        pkt.push_back(8'(u.size()));
                        foreach (u[i]) pkt.push_back(u[i]);
                    end
                endcase
            end
            // Occasional trailing lone size byte, or a unit that overruns the packet end.
            if ($urandom_range(0, 7) == 0) pkt.push_back(8'($urandom));
            if ($urandom_range(0, 7) == 0) begin
                pkt.push_back(8'd0);
                pkt.push_back(8'd40);
                pkt.push_back({3'd0, NAL_SPS});
            end
        end else begin
            repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
        end
        send_packet(pkt);
    endfunction

    // Driver: presents queued byte beats, idling at random.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_ready) begin
            if (drive_enable && byte_queue.size() > 0 &&
                    !(idle_enable && $urandom_range(0, 99) < 24)) begin
                s_data <= byte_queue.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: predicts on accepted byte beats and checks result beats.
    always @(posedge aclk) begin
        out_beat_t want;
        cycle_count <= cycle_count + 1;
        if (aresetn) begin
            if (s_valid && s_ready) predict_byte(s_data);
            if (m_valid && m_ready) begin
                if (size_queue.size() == 0) begin
                    $error("unexpected result beat %p", m_data);
                    error_count++;
                end else begin
                    want = size_queue.pop_front();
                    if (m_data.header_type !== want.header_type) begin
                        $error("header_type: expected %0d actual %0d",
                               want.header_type, m_data.header_type);
                        error_count++;
                    end
                    if (m_data.status !== want.status) begin
                        $error("status: expected %0d actual %0d", want.status, m_data.status);
                        error_count++;
                    end
                    if (m_data.sps_id !== want.sps_id) begin
                        $error("sps_id: expected %0d actual %0d", want.sps_id, m_data.sps_id);
                        error_count++;
                    end
                    if (m_data.frame_width !== want.frame_width) begin
                        $error("frame_width: expected %0d actual %0d",
                               want.frame_width, m_data.frame_width);
                        error_count++;
                    end
                    if (m_data.frame_height !== want.frame_height) begin
                        $error("frame_height: expected %0d actual %0d",
                               want.frame_height, m_data.frame_height);
                        error_count++;
                    end
                end
            end
            m_ready <= !(idle_enable && $urandom_range(0, 99) < 24);
        end
    end

    // Watchdog.
    always @(posedge aclk) begin
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic set_limit(logic [15:0] value);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        len_limit = value;
    endtask

    task automatic drain();
        drive_enable = 1'b1;
        wait (byte_queue.size() == 0 && !s_valid);
        wait (size_queue.size() == 0);
        drive_enable = 1'b0;
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [7:0] pkt[$];
        logic [15:0] limits[5] = '{16'd5, 16'd65535, 16'd1500, 16'd40, 16'd300};
        len_limit = LIMIT_RESET;
        pkt_type = '0;
        clear_packet();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at the reset limit: each status.
        build_sps(pkt, 8'd66, 0);         send_packet(pkt);
        build_sps(pkt, 8'd100, 0);        send_packet(pkt);
        build_sps(pkt, 8'd77, 0);         send_packet(pkt);
        build_sps(pkt, 8'd244, 2);        send_packet(pkt);
        build_sps(pkt, 8'd66, 1);         send_packet(pkt);
        build_sps(pkt, 8'd100, 3);        send_packet(pkt);
        send_packet('{8'hff, 8'h00, 8'hff, 8'h00, 8'h55});
        send_packet('{8'h07, 8'h42});
        send_packet('{8'h18, 8'h00, 8'h00, 8'h00, 8'h02, 8'h01, 8'h02, 8'haa});
        drain();

        // Random phases across several limit settings; idling off for the first.
        foreach (limits[k]) begin
            set_limit(limits[k]);
            idle_enable = (k != 0);
            while (byte_queue.size() < 160) random_packet();
            drain();
        end

        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hsps_pkg.sv
rtl/hsps_sps_walker.sv
rtl/hsps_size_calc.sv
rtl/h264_sps_size_extractor_unit.sv
bench/h264_sps_size_extractor_unit_tb.sv
